>>> rtl/core/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants for the wall-following PD steering block.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // fixed controller constants
  localparam logic signed [17:0] PI_Q12       = 18'sd12861;
  localparam logic [12:0]        NO_ECHO_MM   = 13'd5000;
  localparam logic [8:0]         MOTOR_STOP   = 9'd0;
  localparam logic [8:0]         MOTOR_CORNER = 9'd200;
  localparam logic [8:0]         MOTOR_CRUISE = 9'd400;

  // configuration register indexes
  localparam logic [2:0] CFG_SET_DIST    = 3'd0;
  localparam logic [2:0] CFG_KP          = 3'd1;
  localparam logic [2:0] CFG_KD          = 3'd2;
  localparam logic [2:0] CFG_CORNER_MM   = 3'd3;
  localparam logic [2:0] CFG_TURN_ANGLE  = 3'd4;
  localparam logic [2:0] CFG_SIDE_CRASH  = 3'd5;
  localparam logic [2:0] CFG_FRONT_CRASH = 3'd6;
  localparam logic [2:0] CFG_STEER_LIM   = 3'd7;

  // request to the pd arithmetic unit
  typedef struct packed {
    logic              start;
    logic [15:0]       kp;
    logic [19:0]       kd;
    logic [10:0]       lim;
    logic signed [13:0] err;
    logic signed [14:0] derr;
    logic [31:0]       dt;
  } pd_req_t;

  // response from the pd arithmetic unit
  typedef struct packed {
    logic              done;
    logic signed [11:0] steer;
  } pd_rsp_t;

endpackage

>>> rtl/core/wfs_pd_unit.sv
// ----------------------------------------------------------------------------
// wfs_pd_unit
// Serial PD steering arithmetic: shift-add product over the elapsed time,
// one bit per cycle, then a restoring divide, one quotient bit per cycle,
// with saturation to the steering limit.
// ----------------------------------------------------------------------------
module wfs_pd_unit import wfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pd_req_t req_i,
  output pd_rsp_t rsp_o
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MA   = 3'd1;
  localparam logic [2:0] P_MB   = 3'd2;
  localparam logic [2:0] P_MUL  = 3'd3;
  localparam logic [2:0] P_ABS  = 3'd4;
  localparam logic [2:0] P_CHK  = 3'd5;
  localparam logic [2:0] P_DIV  = 3'd6;
  localparam logic [2:0] P_DONE = 3'd7;

  localparam logic [4:0] MUL_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST = 5'd11;

  logic [2:0]         state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;

  logic [15:0]        kp_q;
  logic [19:0]        kd_q;
  logic [10:0]        lim_q;
  logic signed [13:0] err_q;
  logic signed [14:0] derr_q;
  logic [31:0]        dt_q;
  logic               zdt_q;
  logic signed [30:0] a_q;
  logic signed [62:0] acc_q;
  logic signed [62:0] ash_q;
  logic [31:0]        m_q;
  logic               neg_q;
  logic [61:0]        rem_q;
  logic               sat_q;
  logic [52:0]        dsh_q;
  logic [11:0]        quo_q;

  logic signed [30:0] prod_a;
  logic signed [35:0] prod_b;
  logic signed [62:0] acc_abs;
  logic [61:0]        dsh_x;
  logic               sub_ok;
  logic [11:0]        mag;

  assign prod_a  = $signed({1'b0, kp_q}) * err_q;
  assign prod_b  = $signed({1'b0, kd_q}) * derr_q;
  assign acc_abs = acc_q[62] ? -acc_q : acc_q;
  assign dsh_x   = {9'b0, dsh_q};
  assign sub_ok  = rem_q >= dsh_x;
  assign mag     = (sat_q || (quo_q > {1'b0, lim_q})) ? {1'b0, lim_q} : quo_q;

  assign rsp_o.done  = (state_q == P_DONE);
  assign rsp_o.steer = neg_q ? $signed(mag) : -$signed(mag);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      P_IDLE: begin
        if (req_i.start) begin
          state_d = P_MA;
        end
      end
      P_MA: state_d = P_MB;
      P_MB: begin
        state_d = P_MUL;
        cnt_d   = '0;
      end
      P_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) begin
          state_d = P_ABS;
        end
      end
      P_ABS: state_d = P_CHK;
      P_CHK: begin
        state_d = P_DIV;
        cnt_d   = '0;
      end
      P_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = P_DONE;
        end
      end
      P_DONE: state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        if (req_i.start) begin
          kp_q   <= req_i.kp;
          kd_q   <= req_i.kd;
          lim_q  <= req_i.lim;
          err_q  <= req_i.err;
          derr_q <= req_i.derr;
          zdt_q  <= (req_i.dt == 32'd0);
          dt_q   <= (req_i.dt == 32'd0) ? 32'd1 : req_i.dt;
        end
      end
      P_MA: a_q <= prod_a;
      P_MB: begin
        acc_q <= zdt_q ? '0 : ({{27{prod_b[35]}}, prod_b} << 10);
        ash_q <= {{32{a_q[30]}}, a_q};
        m_q   <= dt_q;
      end
      P_MUL: begin
        if (m_q[0]) begin
          acc_q <= acc_q + ash_q;
        end
        ash_q <= ash_q << 1;
        m_q   <= m_q >> 1;
      end
      P_ABS: begin
        neg_q <= acc_q[62];
        rem_q <= acc_abs[61:0];
      end
      P_CHK: begin
        sat_q <= rem_q >= {8'b0, dt_q, 22'b0};
        dsh_q <= {dt_q, 21'b0};
        quo_q <= '0;
      end
      P_DIV: begin
        if (sub_ok) begin
          rem_q <= rem_q - dsh_x;
        end
        quo_q <= {quo_q[10:0], sub_ok};
        dsh_q <= dsh_q >> 1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == P_IDLE)
    else $error("pd unit started while busy");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == P_DIV |-> cnt_q <= DIV_LAST)
    else $error("divide step count overrun");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == P_DONE |=> state_q == P_IDLE)
    else $error("pd unit did not return to idle");
`endif

endmodule

>>> rtl/core/wall_follow_pd_steering.sv
// Path: repeated, crash and corner ticks pass from the input registers through
//   evaluation to the output register; a wall-following tick also waits on the
//   serial product over the elapsed time and the divide in the PD unit.
// Throughput: one tick at a time; the next input is taken once the tick's
//   result sits in the output register.
// Reset: asynchronous, clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
// wall_follow_pd_steering
// Wall-following steering controller with PD control on the right range and
// a yaw-terminated corner mode, stream input and output.
// ----------------------------------------------------------------------------
module wall_follow_pd_steering import wfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // right_mm[12:0], left_mm[25:13], front_mm[38:26], yaw_angle[53:39],
  // time_us[85:54], zero[87:86]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_level[8:0], steering_level[20:9], corner_mode[21], crash_stop[22],
  // zero[23]
  output logic [23:0] m_axis_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_PD   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;

  logic [12:0] set_q;
  logic [15:0] kp_q;
  logic [19:0] kd_q;
  logic [12:0] corner_q;
  logic [13:0] turn_q;
  logic [12:0] side_q;
  logic [12:0] front_crash_q;
  logic [10:0] lim_q;

  logic               in_corner_q;
  logic               entry_cap_q;
  logic signed [14:0] entry_yaw_q;
  logic signed [13:0] prev_err_q;
  logic [31:0]        prev_time_q;
  logic [12:0]        held_right_q;
  logic [8:0]         held_motor_q;
  logic signed [11:0] held_steer_q;
  logic               crash_q;

  logic [12:0]        right_q, left_q, front_q;
  logic signed [14:0] yaw_q;
  logic [31:0]        time_q;

  logic               out_valid_q;
  logic [23:0]        out_data_q;

  logic               acted, crash, over_range, pd_path, corner_done, wrap;
  logic [12:0]        r_eff;
  logic signed [14:0] ey;
  logic signed [17:0] ey_x, yaw_x, turn_x, sum_x, diff_x, thr_x;
  logic signed [13:0] err;
  logic signed [14:0] derr;
  logic signed [11:0] lim_s;
  logic               out_free;
  pd_req_t            pd_req;
  pd_rsp_t            pd_rsp;

  function automatic logic signed [11:0] clamp_steer(input logic signed [11:0] v,
                                                     input logic [10:0] lim);
    logic signed [11:0] l;
    logic signed [11:0] r;
    l = $signed({1'b0, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign acted = (right_q != held_right_q);
  assign crash = ((right_q != 13'd0) && (right_q < side_q)) ||
                 ((left_q != 13'd0) && (left_q < side_q)) ||
                 ((front_q != 13'd0) && (front_q < front_crash_q));
  assign r_eff      = (right_q == 13'd0) ? NO_ECHO_MM : right_q;
  assign over_range = r_eff > corner_q;
  assign pd_path    = acted && !crash && !in_corner_q && !over_range;

  assign ey     = entry_cap_q ? entry_yaw_q : yaw_q;
  assign ey_x   = 18'(ey);
  assign yaw_x  = 18'(yaw_q);
  assign turn_x = $signed({4'b0, turn_q});
  assign wrap   = ey_x < (turn_x - PI_Q12);
  assign sum_x  = ey_x + PI_Q12;
  assign diff_x = sum_x[17] ? -sum_x : sum_x;
  assign thr_x  = PI_Q12 - (turn_x - diff_x);
  assign corner_done = wrap ? ((yaw_x < thr_x) && (yaw_x > ey_x))
                            : (yaw_x < (ey_x - turn_x));

  assign err   = $signed({1'b0, set_q}) - $signed({1'b0, r_eff});
  assign derr  = $signed({err[13], err}) - $signed({prev_err_q[13], prev_err_q});
  assign lim_s = $signed({1'b0, lim_q});

  assign pd_req.start = (state_q == ST_EVAL) && pd_path;
  assign pd_req.kp    = kp_q;
  assign pd_req.kd    = kd_q;
  assign pd_req.lim   = lim_q;
  assign pd_req.err   = err;
  assign pd_req.derr  = derr;
  assign pd_req.dt    = time_q - prev_time_q;

  wfs_pd_unit u_pd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pd_req),
    .rsp_o  (pd_rsp)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: state_d = pd_path ? ST_PD : ST_FIN;
      ST_PD: begin
        if (pd_rsp.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q         <= 13'd500;
      kp_q          <= 16'd819;
      kd_q          <= 20'd60000;
      corner_q      <= 13'd1500;
      turn_q        <= 14'd5734;
      side_q        <= 13'd100;
      front_crash_q <= 13'd200;
      lim_q         <= 11'd800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_DIST:    set_q         <= cfg_wdata_i[12:0];
        CFG_KP:          kp_q          <= cfg_wdata_i[15:0];
        CFG_KD:          kd_q          <= cfg_wdata_i;
        CFG_CORNER_MM:   corner_q      <= cfg_wdata_i[12:0];
        CFG_TURN_ANGLE:  turn_q        <= cfg_wdata_i[13:0];
        CFG_SIDE_CRASH:  side_q        <= cfg_wdata_i[12:0];
        CFG_FRONT_CRASH: front_crash_q <= cfg_wdata_i[12:0];
        CFG_STEER_LIM:   lim_q         <= cfg_wdata_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_corner_q  <= 1'b0;
      entry_cap_q  <= 1'b0;
      entry_yaw_q  <= '0;
      prev_err_q   <= '0;
      prev_time_q  <= '0;
      held_right_q <= '0;
      held_motor_q <= '0;
      held_steer_q <= '0;
      crash_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EVAL) begin
        crash_q <= acted && crash;
        if (acted) begin
          held_right_q <= ((right_q == 13'd0) && !crash) ? NO_ECHO_MM : right_q;
          if (crash) begin
            held_steer_q <= '0;
            held_motor_q <= MOTOR_STOP;
          end else if (in_corner_q) begin
            entry_cap_q <= 1'b1;
            entry_yaw_q <= ey;
            if (corner_done) begin
              in_corner_q  <= 1'b0;
              held_steer_q <= clamp_steer(held_steer_q, lim_q);
            end else begin
              held_steer_q <= lim_s;
              held_motor_q <= MOTOR_CORNER;
            end
          end else if (over_range) begin
            in_corner_q  <= 1'b1;
            entry_cap_q  <= 1'b0;
            held_steer_q <= lim_s;
            held_motor_q <= MOTOR_CORNER;
          end else begin
            prev_err_q   <= err;
            prev_time_q  <= time_q;
            held_motor_q <= MOTOR_CRUISE;
          end
        end
      end
      if ((state_q == ST_PD) && pd_rsp.done) begin
        held_steer_q <= pd_rsp.steer;
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input capture and output data
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      right_q <= s_axis_tdata[12:0];
      left_q  <= s_axis_tdata[25:13];
      front_q <= s_axis_tdata[38:26];
      yaw_q   <= s_axis_tdata[53:39];
      time_q  <= s_axis_tdata[85:54];
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_data_q <= {1'b0, crash_q, in_corner_q, held_steer_q, held_motor_q};
    end
  end

`ifndef SYNTHESIS
  a_pd_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pd_rsp.done |-> state_q == ST_PD)
    else $error("pd result outside of pd wait");

  a_motor_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_motor_q == MOTOR_STOP || held_motor_q == MOTOR_CORNER ||
    held_motor_q == MOTOR_CRUISE)
    else $error("held motor level out of set");

  a_corner_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_corner_q |-> held_motor_q != MOTOR_CRUISE)
    else $error("cruise drive while in corner mode");
`endif

endmodule

>>> dv/tb_wall_follow_pd_steering.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_follow_pd_steering
// Stream-level check of the wall-following steering block. A local model of
// the PD and corner controller predicts every tick's motor, steering, corner
// and stop outputs; results are compared in order while both stream sides
// idle at random in most phases, under several register settings.
// ----------------------------------------------------------------------------
module tb_wall_follow_pd_steering;
  import wfs_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_AT     = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic               crash;
    logic               corner;
    logic signed [11:0] steer;
    logic [8:0]         motor;
  } steer_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = CFG_SET_DIST;
  logic [19:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // right_mm, left_mm, front_mm, yaw_angle, time_us, zero
  logic [87:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // motor_level, steering_level, corner_mode, crash_stop, zero
  logic [23:0] m_axis_tdata;

  // register copy
  int c_set = 500, c_kp = 819, c_kd = 60000, c_corner = 1500;
  int c_turn = 5734, c_side = 100, c_front = 200, c_lim = 800;

  // controller state copy
  bit          st_in_corner = 1'b0, st_captured = 1'b0;
  int          st_entry_yaw = 0, st_prev_err = 0, st_right = 0, st_steer = 0;
  logic [31:0] st_prev_time = '0;
  logic [8:0]  st_motor     = '0;

  logic [87:0] tick_q[$];
  steer_res_t  steer_exp_q[$];

  int src_idle_pct = 0, snk_idle_pct = 0;
  int mismatch_cnt = 0, results_seen = 0;
  int hold_cnt = 0, stuck_cycles = 0;
  bit hold_done = 1'b0;

  // stimulus generator state
  int          g_right = 0, g_wall = 500, g_yaw = 0;
  logic [31:0] g_time = '0;

  wall_follow_pd_steering dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int clamp_lim(input longint v);
    if (v > c_lim) return c_lim;
    if (v < -c_lim) return -c_lim;
    return int'(v);
  endfunction

  function automatic steer_res_t steer_predict(input logic [87:0] d);
    int          right, left, front, yaw, r, diff, thr, err;
    longint      dtl, derr, num, q;
    logic [31:0] now, dt;
    bit          crash, done;
    steer_res_t  res;
    right = d[12:0];
    left  = d[25:13];
    front = d[38:26];
    yaw   = $signed(d[53:39]);
    now   = d[85:54];
    crash = 1'b0;
    if (right != st_right) begin
      st_right = right;
      crash = (right != 0 && right < c_side) || (left != 0 && left < c_side) ||
              (front != 0 && front < c_front);
      if (crash) begin
        st_motor = MOTOR_STOP;
        st_steer = 0;
      end else begin
        r = (right == 0) ? int'(NO_ECHO_MM) : right;
        st_right = r;
        if (st_in_corner) begin
          if (!st_captured) begin
            st_entry_yaw = yaw;
            st_captured  = 1'b1;
          end
          // entry close to -pi: the end threshold wraps past +pi
          if (st_entry_yaw < c_turn - int'(PI_Q12)) begin
            diff = st_entry_yaw + int'(PI_Q12);
            if (diff < 0) diff = -diff;
            thr  = int'(PI_Q12) - (c_turn - diff);
            done = (yaw < thr) && (yaw > st_entry_yaw);
          end else begin
            done = yaw < st_entry_yaw - c_turn;
          end
          if (done) begin
            st_in_corner = 1'b0;
          end else begin
            st_steer = c_lim;
            st_motor = MOTOR_CORNER;
          end
        end else if (r > c_corner) begin
          st_in_corner = 1'b1;
          st_captured  = 1'b0;
          st_steer     = c_lim;
          st_motor     = MOTOR_CORNER;
        end else begin
          err  = c_set - r;
          derr = longint'(err) - longint'(st_prev_err);
          dt   = now - st_prev_time;
          dtl  = longint'({32'b0, dt});
          if (dt == 0) begin
            q = (longint'(c_kp) * err) / 1024;
          end else begin
            num = longint'(c_kp) * err * dtl + 1024 * longint'(c_kd) * derr;
            q   = num / (1024 * dtl);
          end
          st_prev_err  = err;
          st_motor     = MOTOR_CRUISE;
          st_steer     = clamp_lim(-q);
          st_prev_time = now;
        end
      end
      st_steer = clamp_lim(st_steer);
    end
    res.motor  = st_motor;
    res.steer  = st_steer[11:0];
    res.corner = st_in_corner;
    res.crash  = crash;
    return res;
  endfunction

  task automatic push_tick(input int right, input int left, input int front, input int yaw,
                           input logic [31:0] t);
    logic [12:0] r13, l13, f13;
    logic [14:0] y15;
    r13 = right[12:0];
    l13 = left[12:0];
    f13 = front[12:0];
    y15 = yaw[14:0];
    g_right = right;
    tick_q.push_back({2'b00, t, y15, f13, l13, r13});
  endtask

  function automatic int fresh(input int r);
    if (r != g_right) return r;
    return (r == 8191) ? 8190 : r + 1;
  endfunction

  function automatic int side_range();
    if ($urandom_range(9) == 0) return 0;
    return $urandom_range(3000, 300);
  endfunction

  function automatic logic [31:0] next_time();
    if ($urandom_range(19) != 0) g_time = g_time + 18000 + $urandom_range(4000);
    return g_time;
  endfunction

  task automatic queue_drive(input int n);
    int k, kind, len, hi, i;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        push_tick($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                  int'($urandom_range(32767)) - 16384, $urandom());
        k++;
      end else if (kind < 12) begin
        push_tick(g_right, side_range(), side_range(), g_yaw, next_time());
        k++;
      end else if (kind < 17) begin
        push_tick(fresh($urandom_range(300, 1)), $urandom_range(300), $urandom_range(400),
                  g_yaw, next_time());
        k++;
      end else if (kind < 30 && c_corner < 8191) begin
        // wall end, then a right turn with the yaw falling and wrapping at -pi
        push_tick(fresh($urandom_range(8191, c_corner + 1)), side_range(), side_range(),
                  g_yaw, next_time());
        len = $urandom_range(20, 4);
        for (i = 0; i < len; i++) begin
          g_yaw = g_yaw - int'($urandom_range(900, 150));
          if (g_yaw < -int'(PI_Q12)) g_yaw = g_yaw + 2 * int'(PI_Q12);
          push_tick(fresh($urandom_range(1200, 200)), side_range(), side_range(),
                    g_yaw, next_time());
        end
        k += len + 1;
      end else begin
        hi = (c_corner < 8191) ? c_corner : 8191;
        if (hi < 1) hi = 1;
        g_wall = g_wall + int'($urandom_range(160)) - 80;
        if (g_wall < 1) g_wall = 1;
        if (g_wall > hi) g_wall = hi;
        push_tick(fresh(g_wall), side_range(), side_range(), g_yaw, next_time());
        k++;
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[19:0];
    case (idx)
      CFG_SET_DIST:    c_set    = val & 'h1FFF;
      CFG_KP:          c_kp     = val & 'hFFFF;
      CFG_KD:          c_kd     = val & 'hFFFFF;
      CFG_CORNER_MM:   c_corner = val & 'h1FFF;
      CFG_TURN_ANGLE:  c_turn   = val & 'h3FFF;
      CFG_SIDE_CRASH:  c_side   = val & 'h1FFF;
      CFG_FRONT_CRASH: c_front  = val & 'h1FFF;
      CFG_STEER_LIM:   c_lim    = val & 'h7FF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input int set, input int kp, input int kd, input int corner,
                           input int turn, input int side, input int front, input int lim);
    write_reg(CFG_SET_DIST, set);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KD, kd);
    write_reg(CFG_CORNER_MM, corner);
    write_reg(CFG_TURN_ANGLE, turn);
    write_reg(CFG_SIDE_CRASH, side);
    write_reg(CFG_FRONT_CRASH, front);
    write_reg(CFG_STEER_LIM, lim);
    g_wall = c_set;
  endtask

  task automatic load_plausible();
    load_regs($urandom_range(1000, 200), $urandom_range(4000, 200), $urandom_range(1000000),
              $urandom_range(3000, 1000), $urandom_range(8000, 3000), $urandom_range(150, 20),
              $urandom_range(300, 50), $urandom_range(2047, 1));
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || s_axis_tvalid || steer_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_idle();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) steer_exp_q.push_back(steer_predict(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    steer_res_t got, exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[22:0];
        if (steer_exp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected transfer motor %0d steer %0d corner %0b crash %0b",
                   $time, got.motor, got.steer, got.corner, got.crash);
        end else begin
          exp_res = steer_exp_q.pop_front();
          if (got !== exp_res) begin
            mismatch_cnt++;
            $display("%0t mismatch exp motor %0d steer %0d corner %0b crash %0b", $time,
                     exp_res.motor, exp_res.steer, exp_res.corner, exp_res.crash);
            $display("%0t          got motor %0d steer %0d corner %0b crash %0b", $time,
                     got.motor, got.steer, got.corner, got.crash);
          end
        end
        results_seen++;
      end
      if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= HOLD_AT && !hold_done) begin
        hold_cnt      <= HOLD_CYCLES;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 23;
    snk_idle_pct = 65;

    // reset settings: wall, repeat, zero dt, each stop cause, corners
    push_tick(500, 1000, 1000, 0, 32'd20000);
    push_tick(500, 1000, 1000, 0, 32'd40000);
    push_tick(400, 1000, 1000, 0, 32'd20000);
    push_tick(50, 1000, 1000, 0, 32'd60000);
    push_tick(600, 50, 1000, 0, 32'd60000);
    push_tick(700, 1000, 150, 0, 32'd60000);
    push_tick(8191, 8191, 8191, 0, 32'd80000);
    push_tick(1000, 0, 0, -10000, 32'd100000);
    push_tick(1001, 0, 0, -12000, 32'd120000);
    push_tick(1002, 0, 0, 12500, 32'd140000);
    push_tick(1003, 0, 0, 9000, 32'd160000);
    push_tick(0, 0, 0, 0, 32'd180000);
    push_tick(600, 300, 300, 16383, 32'd200000);
    push_tick(601, 300, 300, -16384, 32'd220000);
    push_tick(450, 300, 300, 0, 32'hFFFF_FFFF);
    push_tick(1500, 300, 300, 0, 32'h0000_4E1F);
    push_tick(1501, 300, 300, 0, 32'h0000_9C3F);
    push_tick(1502, 300, 300, 0, 32'h0000_EA5F);
    push_tick(1503, 300, 300, -5735, 32'h0001_387F);
    push_tick(99, 0, 0, 0, 32'h0001_869F);
    push_tick(100, 100, 200, 0, 32'h0001_D4BF);
    push_tick(1, 0, 0, 0, 32'h0002_22DF);
    push_tick(8190, 8191, 8191, 0, 32'h0002_70FF);
    g_time = $urandom();
    queue_drive(150);
    settle();

    load_regs(0, 65535, 1000000, 0, 0, 0, 0, 1);
    queue_drive(100);
    settle();

    src_idle_pct = 65;
    snk_idle_pct = 23;
    load_regs(8191, 0, 0, 8191, 12868, 8191, 8191, 2047);
    queue_drive(80);
    settle();

    // receiver hold-off falls in this phase
    load_plausible();
    queue_drive(300);
    settle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_plausible();
    queue_drive(150);
    wait_idle();
    queue_drive(150);
    settle();

    load_regs($urandom_range(8191), $urandom_range(65535), $urandom_range(1000000),
              $urandom_range(8191), $urandom_range(12868), $urandom_range(8191),
              $urandom_range(8191), $urandom_range(2047, 1));
    queue_drive(100);
    settle();

    if (mismatch_cnt == 0 && steer_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> wall_follow_pd_steering.f
rtl/core/wfs_pkg.sv
rtl/core/wfs_pd_unit.sv
rtl/core/wall_follow_pd_steering.sv
dv/tb_wall_follow_pd_steering.sv
